// ===== hdl/jddm_pkg.sv =====
// Package for the joystick differential drive mixer: field widths, fixed point
// constants, codes and the structs passed between the front end, queue and back end.
// No dependencies.
package jddm_pkg;

   // Fixed point: a coordinate of COORD_ONE means full deflection.
   localparam int COORD_FRAC_BITS = 12;
   localparam int COORD_ONE       = 1 << COORD_FRAC_BITS;

   // Field widths.
   localparam int POS_W    = 14;
   localparam int RADIUS_W = 13;
   localparam int ANGLE_W  = 15;
   localparam int CLASS_W  = 3;
   localparam int DIR_W    = 2;
   localparam int DUTY_W   = 14;

   localparam int DUTY_FULL         = 10000;
   localparam int DUTY_MAX_RESET    = 10000;
   localparam int DUTY_OFFSET_RESET = 500;
   localparam int ANGLE_FULL        = 9000;

   // Internal widths.
   localparam int MAG_W  = COORD_FRAC_BITS + 1;   // saturated magnitude, up to COORD_ONE
   localparam int AMAG_W = 14;                    // saturated angle magnitude, up to 9000
   localparam int BASE_W = MAG_W + DUTY_W;        // magnitude * range + offset * one
   localparam int PROD_W = BASE_W + AMAG_W;       // base * angle
   localparam int QUOT_W = 27;                    // (base * angle) / one, below 2^27

   // Division by ANGLE_FULL as a multiplication by a scaled reciprocal.
   localparam int              RECIP_SHIFT = 40;
   localparam int              RECIP_W     = 27;
   localparam longint unsigned RECIP       = (64'd1 << RECIP_SHIFT) / ANGLE_FULL;
   localparam int              RPROD_W     = QUOT_W + RECIP_W;

   localparam longint unsigned BASE_HALF  = COORD_ONE / 2;
   localparam longint unsigned INNER_HALF = (longint'(COORD_ONE) * ANGLE_FULL) / 2;

   // Back end queue.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [DIR_W-1:0] {
      DIR_IDLE = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_CENTER       = 3'd0,
      CLASS_Y_AXIS       = 3'd1,
      CLASS_X_AXIS       = 3'd2,
      CLASS_TOP_RIGHT    = 3'd3,
      CLASS_TOP_LEFT     = 3'd4,
      CLASS_BOTTOM_LEFT  = 3'd5,
      CLASS_BOTTOM_RIGHT = 3'd6
   } class_type;

   typedef enum logic [1:0] {
      SEL_ZERO  = 2'd0,
      SEL_OUTER = 2'd1,
      SEL_INNER = 2'd2
   } duty_sel_type;

   typedef enum logic [1:0] {
      REG_DUTY_MAX    = 2'd0,
      REG_DUTY_OFFSET = 2'd1,
      REG_ALT_MAPPING = 2'd2
   } reg_index_type;

   typedef struct packed {
      dir_type      left_dir;
      dir_type      right_dir;
      duty_sel_type left_sel;
      duty_sel_type right_sel;
   } ctl_type;

   typedef struct packed {
      ctl_type             ctl;
      logic [MAG_W-1:0]    mag;
      logic [AMAG_W-1:0]   angle;
   } job_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_range;
      logic [DUTY_W-1:0] duty_offset;
      logic              alt_mapping;
   } cfg_type;

endpackage

// ===== hdl/jddm_ifs.sv =====
// Valid/ready channel interfaces for joystick samples and motor commands.
// Depends on jddm_pkg for the field widths.
interface jddm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [jddm_pkg::POS_W-1:0]    pos_x;
   logic signed [jddm_pkg::POS_W-1:0]    pos_y;
   logic        [jddm_pkg::RADIUS_W-1:0] stick_radius;
   logic signed [jddm_pkg::ANGLE_W-1:0]  stick_angle;
   logic        [jddm_pkg::CLASS_W-1:0]  stick_class;

   modport source (output valid, pos_x, pos_y, stick_radius, stick_angle, stick_class,
                   input ready);
   modport sink (input valid, pos_x, pos_y, stick_radius, stick_angle, stick_class,
                 output ready);
endinterface

interface jddm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [jddm_pkg::DIR_W-1:0]         left_dir;
   logic [jddm_pkg::DUTY_W-1:0]        left_duty;
   logic [jddm_pkg::DIR_W-1:0]         right_dir;
   logic [jddm_pkg::DUTY_W-1:0]        right_duty;

   modport source (output valid, left_dir, left_duty, right_dir, right_duty, input ready);
   modport sink (input valid, left_dir, left_duty, right_dir, right_duty, output ready);
endinterface

// ===== hdl/joystick_differential_drive_mixer.sv =====
// Top level of the joystick differential drive mixer: configuration registers,
// front end, job queue and duty pipeline. Depends on jddm_pkg, the channel
// interfaces, jddm_front, jddm_queue and jddm_back.
//
// Usage:
//   req_chan carries one evaluated joystick sample per beat (coordinates, radius,
//   angle and position class); rsp_chan carries one motor command per beat
//   (direction and duty for the left and right motor). Every sample gives
//   exactly one command, in order.
//   A sample is written into the queue and then passes the six stage duty
//   pipeline in the back end, whose longest stages are one multiplier each.
//   Throughput: one sample per cycle while the receiver keeps up.
//   A four entry queue sits between the classifying front end and the pipeline,
//   so req_chan.ready stays high while the queue has room.
//   When the receiver stalls, the result register holds its command and the
//   pipeline freezes; the queue then fills and req_chan.ready falls.
//   Reset empties the queue and pipeline and loads duty_max = 10000,
//   duty_offset = 500 and alt_mapping = 0. The registers are written through the
//   csr_ port (duty_max at 0x0, duty_offset at 0x4, alt_mapping at 0x8); the user
//   must write them only while no sample is in flight, as the block does not enforce it.
module joystick_differential_drive_mixer (
   input  logic                              clock,
   input  logic                              reset,
   jddm_req_if.sink                          req_chan,
   jddm_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [jddm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [jddm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [jddm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   logic [jddm_pkg::DUTY_W-1:0]   duty_max_ff;
   logic [jddm_pkg::DUTY_W-1:0]   duty_offset_ff;
   logic                          alt_mapping_ff;
   jddm_pkg::cfg_type             cfg_ff;
   jddm_pkg::cfg_type             cfg_in;
   logic [jddm_pkg::DUTY_W-1:0]   dmax_sat;
   logic [jddm_pkg::DUTY_W-1:0]   doff_sat;
   logic [1:0]                    reg_index;
   logic                          csr_write;

   logic                          push;
   jddm_pkg::job_type             push_job;
   logic                          queue_full;
   logic                          pop;
   logic                          job_valid;
   jddm_pkg::job_type             job;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_max_ff    <= jddm_pkg::DUTY_W'(jddm_pkg::DUTY_MAX_RESET);
         duty_offset_ff <= jddm_pkg::DUTY_W'(jddm_pkg::DUTY_OFFSET_RESET);
         alt_mapping_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (reg_index)
            jddm_pkg::REG_DUTY_MAX:    duty_max_ff    <= csr_pwdata[jddm_pkg::DUTY_W-1:0];
            jddm_pkg::REG_DUTY_OFFSET: duty_offset_ff <= csr_pwdata[jddm_pkg::DUTY_W-1:0];
            jddm_pkg::REG_ALT_MAPPING: alt_mapping_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         jddm_pkg::REG_DUTY_MAX:    csr_prdata = jddm_pkg::CSR_DATA_W'(duty_max_ff);
         jddm_pkg::REG_DUTY_OFFSET: csr_prdata = jddm_pkg::CSR_DATA_W'(duty_offset_ff);
         jddm_pkg::REG_ALT_MAPPING: csr_prdata = jddm_pkg::CSR_DATA_W'(alt_mapping_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // Saturated duty settings and the range above the offset, registered so that
   // the pipeline multiplier sees them straight from flip-flops.
   assign dmax_sat = (int'(duty_max_ff) > jddm_pkg::DUTY_FULL) ?
                     jddm_pkg::DUTY_W'(jddm_pkg::DUTY_FULL) : duty_max_ff;
   assign doff_sat = (int'(duty_offset_ff) > jddm_pkg::DUTY_FULL) ?
                     jddm_pkg::DUTY_W'(jddm_pkg::DUTY_FULL) : duty_offset_ff;

   always_comb begin
      cfg_in.duty_range  = (dmax_sat >= doff_sat) ? dmax_sat - doff_sat : '0;
      cfg_in.duty_offset = doff_sat;
      cfg_in.alt_mapping = alt_mapping_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_range  <= jddm_pkg::DUTY_W'(jddm_pkg::DUTY_MAX_RESET -
                                                 jddm_pkg::DUTY_OFFSET_RESET);
         cfg_ff.duty_offset <= jddm_pkg::DUTY_W'(jddm_pkg::DUTY_OFFSET_RESET);
         cfg_ff.alt_mapping <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jddm_front u_front (
      .req_chan    (req_chan),
      .alt_mapping (cfg_ff.alt_mapping),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   jddm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (job_valid),
      .pop_job   (job)
   );

   jddm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job       (job),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== hdl/jddm_front.sv =====
// Front end: takes joystick samples, saturates magnitudes and decides directions
// and duty selection per wheel. Depends on jddm_pkg and jddm_req_if.
module jddm_front (
   jddm_req_if.sink            req_chan,
   input  logic                alt_mapping,
   input  logic                queue_full,
   output logic                push,
   output jddm_pkg::job_type   push_job
);

   logic [jddm_pkg::POS_W-1:0]    abs_x;
   logic [jddm_pkg::POS_W-1:0]    abs_y;
   logic [jddm_pkg::ANGLE_W-1:0]  abs_angle;
   logic [jddm_pkg::MAG_W-1:0]    mag_x;
   logic [jddm_pkg::MAG_W-1:0]    mag_y;
   logic [jddm_pkg::MAG_W-1:0]    mag_r;
   logic [jddm_pkg::AMAG_W-1:0]   mag_angle;
   logic [jddm_pkg::CLASS_W-1:0]  cls;
   logic                          x_pos;
   logic                          y_pos;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   // Two's complement magnitudes; the most negative code still fits unsigned.
   assign abs_x     = req_chan.pos_x[jddm_pkg::POS_W-1] ?
                      (~req_chan.pos_x + 1'b1) : req_chan.pos_x;
   assign abs_y     = req_chan.pos_y[jddm_pkg::POS_W-1] ?
                      (~req_chan.pos_y + 1'b1) : req_chan.pos_y;
   assign abs_angle = req_chan.stick_angle[jddm_pkg::ANGLE_W-1] ?
                      (~req_chan.stick_angle + 1'b1) : req_chan.stick_angle;

   assign mag_x = (int'(abs_x) > jddm_pkg::COORD_ONE) ?
                  jddm_pkg::MAG_W'(jddm_pkg::COORD_ONE) : jddm_pkg::MAG_W'(abs_x);
   assign mag_y = (int'(abs_y) > jddm_pkg::COORD_ONE) ?
                  jddm_pkg::MAG_W'(jddm_pkg::COORD_ONE) : jddm_pkg::MAG_W'(abs_y);
   assign mag_r = (int'(req_chan.stick_radius) > jddm_pkg::COORD_ONE) ?
                  jddm_pkg::MAG_W'(jddm_pkg::COORD_ONE) :
                  jddm_pkg::MAG_W'(req_chan.stick_radius);
   assign mag_angle = (int'(abs_angle) > jddm_pkg::ANGLE_FULL) ?
                      jddm_pkg::AMAG_W'(jddm_pkg::ANGLE_FULL) :
                      jddm_pkg::AMAG_W'(abs_angle);

   assign x_pos = !req_chan.pos_x[jddm_pkg::POS_W-1] && (req_chan.pos_x != '0);
   assign y_pos = !req_chan.pos_y[jddm_pkg::POS_W-1] && (req_chan.pos_y != '0);

   always_comb begin
      cls = req_chan.stick_class;
      if (alt_mapping) begin
         if (req_chan.stick_class == jddm_pkg::CLASS_BOTTOM_LEFT) begin
            cls = jddm_pkg::CLASS_BOTTOM_RIGHT;
         end else if (req_chan.stick_class == jddm_pkg::CLASS_BOTTOM_RIGHT) begin
            cls = jddm_pkg::CLASS_BOTTOM_LEFT;
         end
      end
   end

   always_comb begin
      push_job.ctl.left_dir  = jddm_pkg::DIR_IDLE;
      push_job.ctl.right_dir = jddm_pkg::DIR_IDLE;
      push_job.ctl.left_sel  = jddm_pkg::SEL_ZERO;
      push_job.ctl.right_sel = jddm_pkg::SEL_ZERO;
      push_job.mag           = mag_r;
      push_job.angle         = mag_angle;
      unique case (cls)
         jddm_pkg::CLASS_Y_AXIS: begin
            push_job.ctl.left_dir  = y_pos ? jddm_pkg::DIR_FWD : jddm_pkg::DIR_REV;
            push_job.ctl.right_dir = y_pos ? jddm_pkg::DIR_FWD : jddm_pkg::DIR_REV;
            push_job.ctl.left_sel  = jddm_pkg::SEL_OUTER;
            push_job.ctl.right_sel = jddm_pkg::SEL_OUTER;
            push_job.mag           = mag_y;
         end
         jddm_pkg::CLASS_X_AXIS: begin
            push_job.ctl.left_dir  = x_pos ? jddm_pkg::DIR_FWD : jddm_pkg::DIR_REV;
            push_job.ctl.right_dir = x_pos ? jddm_pkg::DIR_REV : jddm_pkg::DIR_FWD;
            push_job.ctl.left_sel  = jddm_pkg::SEL_OUTER;
            push_job.ctl.right_sel = jddm_pkg::SEL_OUTER;
            push_job.mag           = mag_x;
         end
         jddm_pkg::CLASS_TOP_RIGHT: begin
            push_job.ctl.left_dir  = jddm_pkg::DIR_FWD;
            push_job.ctl.right_dir = jddm_pkg::DIR_FWD;
            push_job.ctl.left_sel  = jddm_pkg::SEL_OUTER;
            push_job.ctl.right_sel = jddm_pkg::SEL_INNER;
         end
         jddm_pkg::CLASS_TOP_LEFT: begin
            push_job.ctl.left_dir  = jddm_pkg::DIR_FWD;
            push_job.ctl.right_dir = jddm_pkg::DIR_FWD;
            push_job.ctl.left_sel  = jddm_pkg::SEL_INNER;
            push_job.ctl.right_sel = jddm_pkg::SEL_OUTER;
         end
         jddm_pkg::CLASS_BOTTOM_LEFT: begin
            push_job.ctl.left_dir  = jddm_pkg::DIR_REV;
            push_job.ctl.right_dir = jddm_pkg::DIR_REV;
            push_job.ctl.left_sel  = jddm_pkg::SEL_OUTER;
            push_job.ctl.right_sel = jddm_pkg::SEL_INNER;
         end
         jddm_pkg::CLASS_BOTTOM_RIGHT: begin
            push_job.ctl.left_dir  = jddm_pkg::DIR_REV;
            push_job.ctl.right_dir = jddm_pkg::DIR_REV;
            push_job.ctl.left_sel  = jddm_pkg::SEL_INNER;
            push_job.ctl.right_sel = jddm_pkg::SEL_OUTER;
         end
         default: begin
            // Center and the unused class code leave both motors idle.
         end
      endcase
   end

endmodule

// ===== hdl/jddm_queue.sv =====
// Short first-in first-out queue of classified jobs between front and back end.
// Depends on jddm_pkg.
module jddm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jddm_pkg::job_type   push_job,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output jddm_pkg::job_type   pop_job
);

   jddm_pkg::job_type                 entry_ff [jddm_pkg::QUEUE_DEPTH];
   logic [jddm_pkg::QPTR_W-1:0]       wptr_ff;
   logic [jddm_pkg::QPTR_W-1:0]       wptr_in;
   logic [jddm_pkg::QPTR_W-1:0]       rptr_ff;
   logic [jddm_pkg::QPTR_W-1:0]       rptr_in;
   logic [jddm_pkg::QCNT_W-1:0]       count_ff;
   logic [jddm_pkg::QCNT_W-1:0]       count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full      = (count_ff == jddm_pkg::QCNT_W'(jddm_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job   = entry_ff[rptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_job;
      end
   end

endmodule

// ===== hdl/jddm_back.sv =====
// Back end: six stage duty pipeline with the result register as its last stage.
// The whole pipeline stalls when the result is held. Depends on jddm_pkg, jddm_rsp_if.
module jddm_back (
   input  logic                clock,
   input  logic                reset,
   input  jddm_pkg::cfg_type   cfg,
   input  logic                job_valid,
   input  jddm_pkg::job_type   job,
   output logic                pop,
   jddm_rsp_if.source          rsp_chan
);

   logic                                  advance;

   logic                                  s1_valid_ff;
   jddm_pkg::ctl_type                     s1_ctl_ff;
   logic [jddm_pkg::AMAG_W-1:0]           s1_angle_ff;
   logic [jddm_pkg::BASE_W-1:0]           s1_prod_ff;
   logic [jddm_pkg::BASE_W-1:0]           s1_prod_in;

   logic                                  s2_valid_ff;
   jddm_pkg::ctl_type                     s2_ctl_ff;
   logic [jddm_pkg::AMAG_W-1:0]           s2_angle_ff;
   logic [jddm_pkg::BASE_W-1:0]           s2_base_ff;
   logic [jddm_pkg::BASE_W-1:0]           s2_base_in;

   logic                                  s3_valid_ff;
   jddm_pkg::ctl_type                     s3_ctl_ff;
   logic [jddm_pkg::PROD_W-1:0]           s3_scaled_ff;
   logic [jddm_pkg::PROD_W-1:0]           s3_scaled_in;
   logic [jddm_pkg::DUTY_W-1:0]           s3_outer_ff;
   logic [jddm_pkg::DUTY_W-1:0]           s3_outer_in;
   logic [jddm_pkg::BASE_W:0]             s3_round;

   logic                                  s4_valid_ff;
   jddm_pkg::ctl_type                     s4_ctl_ff;
   logic [jddm_pkg::DUTY_W-1:0]           s4_outer_ff;
   logic [jddm_pkg::QUOT_W-1:0]           s4_quot_ff;
   logic [jddm_pkg::QUOT_W-1:0]           s4_quot_in;
   logic [jddm_pkg::PROD_W:0]             s4_round;

   logic                                  s5_valid_ff;
   jddm_pkg::ctl_type                     s5_ctl_ff;
   logic [jddm_pkg::DUTY_W-1:0]           s5_outer_ff;
   logic [jddm_pkg::QUOT_W-1:0]           s5_quot_ff;
   logic [jddm_pkg::DUTY_W-1:0]           s5_est_ff;
   logic [jddm_pkg::DUTY_W-1:0]           s5_est_in;
   logic [jddm_pkg::RPROD_W-1:0]          s5_rprod;

   logic                                  out_valid_ff;
   logic [jddm_pkg::DIR_W-1:0]            out_left_dir_ff;
   logic [jddm_pkg::DUTY_W-1:0]           out_left_duty_ff;
   logic [jddm_pkg::DIR_W-1:0]            out_right_dir_ff;
   logic [jddm_pkg::DUTY_W-1:0]           out_right_duty_ff;
   logic [jddm_pkg::DUTY_W-1:0]           out_left_duty_in;
   logic [jddm_pkg::DUTY_W-1:0]           out_right_duty_in;
   logic [jddm_pkg::QUOT_W-1:0]           s6_rem;
   logic [jddm_pkg::DUTY_W-1:0]           s6_inner;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign pop     = advance && job_valid;

   // Stage 1: magnitude times duty range.
   assign s1_prod_in = jddm_pkg::BASE_W'(job.mag) * jddm_pkg::BASE_W'(cfg.duty_range);

   // Stage 2: add the starting duty scaled to the coordinate fixed point.
   assign s2_base_in = s1_prod_ff +
                       (jddm_pkg::BASE_W'(cfg.duty_offset) << jddm_pkg::COORD_FRAC_BITS);

   // Stage 3: outer duty rounded; base times angle for the inner wheel.
   assign s3_round     = (jddm_pkg::BASE_W+1)'(s2_base_ff) +
                         (jddm_pkg::BASE_W+1)'(jddm_pkg::BASE_HALF);
   assign s3_outer_in  = jddm_pkg::DUTY_W'(s3_round >> jddm_pkg::COORD_FRAC_BITS);
   assign s3_scaled_in = jddm_pkg::PROD_W'(s2_base_ff) * jddm_pkg::PROD_W'(s2_angle_ff);

   // Stage 4: add half the divisor, then drop the coordinate fraction; the
   // remaining division by the full angle is exact on the truncated value.
   assign s4_round   = (jddm_pkg::PROD_W+1)'(s3_scaled_ff) +
                       (jddm_pkg::PROD_W+1)'(jddm_pkg::INNER_HALF);
   assign s4_quot_in = jddm_pkg::QUOT_W'(s4_round >> jddm_pkg::COORD_FRAC_BITS);

   // Stage 5: quotient estimate from the reciprocal, low by at most one.
   assign s5_rprod  = jddm_pkg::RPROD_W'(s4_quot_ff) * jddm_pkg::RPROD_W'(jddm_pkg::RECIP);
   assign s5_est_in = s5_rprod[jddm_pkg::RECIP_SHIFT +: jddm_pkg::DUTY_W];

   // Stage 6: correct the estimate and pick each wheel's duty.
   assign s6_rem   = s5_quot_ff -
                     jddm_pkg::QUOT_W'(s5_est_ff * jddm_pkg::QUOT_W'(jddm_pkg::ANGLE_FULL));
   assign s6_inner = (s6_rem >= jddm_pkg::QUOT_W'(jddm_pkg::ANGLE_FULL)) ?
                     s5_est_ff + 1'b1 : s5_est_ff;

   always_comb begin
      unique case (s5_ctl_ff.left_sel)
         jddm_pkg::SEL_OUTER: out_left_duty_in = s5_outer_ff;
         jddm_pkg::SEL_INNER: out_left_duty_in = s6_inner;
         default:             out_left_duty_in = '0;
      endcase
      unique case (s5_ctl_ff.right_sel)
         jddm_pkg::SEL_OUTER: out_right_duty_in = s5_outer_ff;
         jddm_pkg::SEL_INNER: out_right_duty_in = s6_inner;
         default:             out_right_duty_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= job_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         out_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ctl_ff         <= job.ctl;
         s1_angle_ff       <= job.angle;
         s1_prod_ff        <= s1_prod_in;
         s2_ctl_ff         <= s1_ctl_ff;
         s2_angle_ff       <= s1_angle_ff;
         s2_base_ff        <= s2_base_in;
         s3_ctl_ff         <= s2_ctl_ff;
         s3_scaled_ff      <= s3_scaled_in;
         s3_outer_ff       <= s3_outer_in;
         s4_ctl_ff         <= s3_ctl_ff;
         s4_outer_ff       <= s3_outer_ff;
         s4_quot_ff        <= s4_quot_in;
         s5_ctl_ff         <= s4_ctl_ff;
         s5_outer_ff       <= s4_outer_ff;
         s5_quot_ff        <= s4_quot_ff;
         s5_est_ff         <= s5_est_in;
         out_left_dir_ff   <= s5_ctl_ff.left_dir;
         out_right_dir_ff  <= s5_ctl_ff.right_dir;
         out_left_duty_ff  <= out_left_duty_in;
         out_right_duty_ff <= out_right_duty_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.left_dir   = out_left_dir_ff;
   assign rsp_chan.left_duty  = out_left_duty_ff;
   assign rsp_chan.right_dir  = out_right_dir_ff;
   assign rsp_chan.right_duty = out_right_duty_ff;

endmodule

// ===== hdl/jddm_checker.sv =====
// Port level checks on the motor command channel of the mixer, bound to the top
// level. Depends on jddm_pkg and joystick_differential_drive_mixer.
module jddm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [jddm_pkg::DIR_W-1:0]    left_dir,
   input logic [jddm_pkg::DUTY_W-1:0]   left_duty,
   input logic [jddm_pkg::DIR_W-1:0]    right_dir,
   input logic [jddm_pkg::DUTY_W-1:0]   right_duty
);

   // A held command stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("command beat dropped while stalled");

   // A held command does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(left_dir) && $stable(left_duty) && $stable(right_dir) && $stable(right_duty))
      else $error("command beat changed while stalled");

   // Idle on the left motor means both motors are idle with zero duty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (left_dir == jddm_pkg::DIR_IDLE) |->
         (right_dir == jddm_pkg::DIR_IDLE) && (left_duty == '0) && (right_duty == '0))
      else $error("idle command with a running motor");

   // Duties never exceed full scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(left_duty) <= jddm_pkg::DUTY_FULL) &&
                    (int'(right_duty) <= jddm_pkg::DUTY_FULL))
      else $error("duty above full scale");

endmodule

bind joystick_differential_drive_mixer jddm_checker u_jddm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .left_dir   (rsp_chan.left_dir),
   .left_duty  (rsp_chan.left_duty),
   .right_dir  (rsp_chan.right_dir),
   .right_duty (rsp_chan.right_duty)
);

// ===== test/tb_joystick_differential_drive_mixer.sv =====
// Self-checking testbench for joystick_differential_drive_mixer: drives samples
// under several register settings and idling patterns and checks every command.
// Depends on jddm_pkg, the channel interfaces in jddm_ifs.sv and the RTL.
module tb_joystick_differential_drive_mixer;
   import jddm_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic signed [POS_W-1:0]    pos_x;
      logic signed [POS_W-1:0]    pos_y;
      logic        [RADIUS_W-1:0] stick_radius;
      logic signed [ANGLE_W-1:0]  stick_angle;
      logic        [CLASS_W-1:0]  stick_class;
   } stick_sample_type;

   typedef struct packed {
      dir_type           left_dir;
      logic [DUTY_W-1:0] left_duty;
      dir_type           right_dir;
      logic [DUTY_W-1:0] right_duty;
   } motor_cmd_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   jddm_req_if req_chan ();
   jddm_rsp_if rsp_chan ();

   joystick_differential_drive_mixer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Register copies used by the predictor.
   logic [DUTY_W-1:0] cfg_duty_max;
   logic [DUTY_W-1:0] cfg_duty_offset;
   logic              cfg_alt_mapping;

   stick_sample_type pending_samples[$];
   motor_cmd_type    expected_cmds[$];
   stick_sample_type next_sample;

   int  send_idle_pct;
   int  recv_stall_pct;
   int  mismatch_count;
   int  cycle_count;
   int  hold_left;
   logic hold_arm;
   logic req_taken;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned clip_mag(longint v, longint unsigned limit);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      return (m > limit) ? limit : m;
   endfunction

   // Expected motor command for one sample under the current register copies.
   function automatic motor_cmd_type mix_drive(stick_sample_type s);
      longint unsigned one, dmax, doff, span, rad, ang, base, outer, inner, axis_duty;
      logic [CLASS_W-1:0] cls;
      motor_cmd_type c;
      one  = COORD_ONE;
      dmax = (cfg_duty_max > DUTY_FULL) ? DUTY_FULL : cfg_duty_max;
      doff = (cfg_duty_offset > DUTY_FULL) ? DUTY_FULL : cfg_duty_offset;
      span = (dmax >= doff) ? dmax - doff : 0;
      rad  = (s.stick_radius > one) ? one : s.stick_radius;
      ang  = clip_mag(longint'($signed(s.stick_angle)), ANGLE_FULL);
      cls  = s.stick_class;
      if (cfg_alt_mapping) begin
         if (cls == CLASS_BOTTOM_LEFT) cls = CLASS_BOTTOM_RIGHT;
         else if (cls == CLASS_BOTTOM_RIGHT) cls = CLASS_BOTTOM_LEFT;
      end
      c.left_dir   = DIR_IDLE;
      c.right_dir  = DIR_IDLE;
      c.left_duty  = '0;
      c.right_duty = '0;
      case (cls)
         CLASS_Y_AXIS: begin
            axis_duty = (clip_mag(longint'($signed(s.pos_y)), one) * span + doff * one
                         + one / 2) / one;
            c.left_dir   = ($signed(s.pos_y) > 0) ? DIR_FWD : DIR_REV;
            c.right_dir  = c.left_dir;
            c.left_duty  = axis_duty[DUTY_W-1:0];
            c.right_duty = axis_duty[DUTY_W-1:0];
         end
         CLASS_X_AXIS: begin
            axis_duty = (clip_mag(longint'($signed(s.pos_x)), one) * span + doff * one
                         + one / 2) / one;
            c.left_dir   = ($signed(s.pos_x) > 0) ? DIR_FWD : DIR_REV;
            c.right_dir  = ($signed(s.pos_x) > 0) ? DIR_REV : DIR_FWD;
            c.left_duty  = axis_duty[DUTY_W-1:0];
            c.right_duty = axis_duty[DUTY_W-1:0];
         end
         CLASS_TOP_RIGHT, CLASS_TOP_LEFT, CLASS_BOTTOM_LEFT, CLASS_BOTTOM_RIGHT: begin
            base  = rad * span + doff * one;
            outer = (base + one / 2) / one;
            inner = (base * ang + (one * ANGLE_FULL) / 2) / (one * ANGLE_FULL);
            c.left_dir  = (cls == CLASS_TOP_RIGHT || cls == CLASS_TOP_LEFT) ? DIR_FWD : DIR_REV;
            c.right_dir = c.left_dir;
            // The left wheel is the outer one in the top right and bottom left classes.
            if (cls == CLASS_TOP_RIGHT || cls == CLASS_BOTTOM_LEFT) begin
               c.left_duty  = outer[DUTY_W-1:0];
               c.right_duty = inner[DUTY_W-1:0];
            end else begin
               c.left_duty  = inner[DUTY_W-1:0];
               c.right_duty = outer[DUTY_W-1:0];
            end
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic check_field(string name, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Sample driver: a new beat is offered once the previous one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_sample = pending_samples.pop_front();
            req_chan.pos_x        <= next_sample.pos_x;
            req_chan.pos_y        <= next_sample.pos_y;
            req_chan.stick_radius <= next_sample.stick_radius;
            req_chan.stick_angle  <= next_sample.stick_angle;
            req_chan.stick_class  <= next_sample.stick_class;
            req_chan.valid        <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted here and armed by the stimulus.
   always @(negedge clock) begin
      if (hold_arm) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !reset && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
   end

   // Monitor: checks command beats and predicts each accepted sample.
   always @(posedge clock) begin
      motor_cmd_type want;
      stick_sample_type taken;
      req_taken <= req_chan.valid && req_chan.ready;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_cmds.size() == 0) begin
            $display("%0t: unexpected command beat: left %0d/%0d right %0d/%0d", $time,
                     rsp_chan.left_dir, rsp_chan.left_duty, rsp_chan.right_dir,
                     rsp_chan.right_duty);
            mismatch_count++;
         end else begin
            want = expected_cmds.pop_front();
            check_field("left_dir", DUTY_W'(want.left_dir), DUTY_W'(rsp_chan.left_dir));
            check_field("left_duty", want.left_duty, rsp_chan.left_duty);
            check_field("right_dir", DUTY_W'(want.right_dir), DUTY_W'(rsp_chan.right_dir));
            check_field("right_duty", want.right_duty, rsp_chan.right_duty);
         end
      end
      if (!reset && req_chan.valid && req_chan.ready) begin
         taken.pos_x        = req_chan.pos_x;
         taken.pos_y        = req_chan.pos_y;
         taken.stick_radius = req_chan.stick_radius;
         taken.stick_angle  = req_chan.stick_angle;
         taken.stick_class  = req_chan.stick_class;
         expected_cmds.push_back(mix_drive(taken));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_joystick_differential_drive_mixer failed");
         $finish;
      end
   end

   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_DUTY_MAX:    cfg_duty_max    = value[DUTY_W-1:0];
         REG_DUTY_OFFSET: cfg_duty_offset = value[DUTY_W-1:0];
         REG_ALT_MAPPING: cfg_alt_mapping = value[0];
         default: ;
      endcase
   endtask

   task automatic push_sample(int x, int y, int r, int a, int c);
      stick_sample_type s;
      s.pos_x        = POS_W'(x);
      s.pos_y        = POS_W'(y);
      s.stick_radius = RADIUS_W'(r);
      s.stick_angle  = ANGLE_W'(a);
      s.stick_class  = CLASS_W'(c);
      pending_samples.push_back(s);
   endtask

   function automatic int pick_edge(int lo, int hi);
      case ($urandom_range(3))
         0: return lo;
         1: return hi;
         2: return 0;
         default: return (hi > 1) ? 1 : lo;
      endcase
   endfunction

   task automatic push_random_sample();
      stick_sample_type s;
      logic [63:0] raw;
      int roll;
      roll = $urandom_range(99);
      if (roll < 12) begin
         // Raw bit patterns reach the saturation paths and the unused class.
         raw = {$urandom, $urandom};
         s = raw[$bits(stick_sample_type)-1:0];
         pending_samples.push_back(s);
      end else if (roll < 30) begin
         push_sample(pick_edge(-COORD_ONE, COORD_ONE), pick_edge(-COORD_ONE, COORD_ONE),
                     pick_edge(0, COORD_ONE), pick_edge(-ANGLE_FULL, ANGLE_FULL),
                     $urandom_range(CLASS_BOTTOM_RIGHT));
      end else begin
         push_sample(int'($urandom_range(2 * COORD_ONE)) - COORD_ONE,
                     int'($urandom_range(2 * COORD_ONE)) - COORD_ONE,
                     $urandom_range(COORD_ONE),
                     int'($urandom_range(2 * ANGLE_FULL)) - ANGLE_FULL,
                     $urandom_range(CLASS_BOTTOM_RIGHT));
      end
   endtask

   // Waits until every sample has been taken and every command has arrived.
   task automatic wait_idle();
      do @(posedge clock); while (pending_samples.size() != 0 || req_chan.valid);
      do @(negedge clock); while (expected_cmds.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(int dmax, int doff, int alt, int send_pct, int recv_pct,
                            int count, bit long_hold);
      write_reg(REG_DUTY_MAX, dmax);
      write_reg(REG_DUTY_OFFSET, doff);
      write_reg(REG_ALT_MAPPING, alt);
      @(posedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) push_random_sample();
      if (long_hold) begin
         repeat (20) @(negedge clock);
         hold_arm <= 1'b1;
         @(negedge clock);
         hold_arm <= 1'b0;
      end
      wait_idle();
   endtask

   initial begin
      reset          = 1'b1;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      hold_arm       = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      cfg_duty_max    = DUTY_W'(DUTY_MAX_RESET);
      cfg_duty_offset = DUTY_W'(DUTY_OFFSET_RESET);
      cfg_alt_mapping = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under the reset register values.
      push_sample(1000, 2000, 3000, 4000, CLASS_CENTER);
      push_sample(-8192, 8191, 8191, 16383, 7);
      push_sample(0, COORD_ONE, 0, 0, CLASS_Y_AXIS);
      push_sample(0, -COORD_ONE, 0, 0, CLASS_Y_AXIS);
      push_sample(0, 0, 0, 0, CLASS_Y_AXIS);
      push_sample(0, 1, 0, 0, CLASS_Y_AXIS);
      push_sample(0, 8191, 0, 0, CLASS_Y_AXIS);
      push_sample(COORD_ONE, 0, 0, 0, CLASS_X_AXIS);
      push_sample(-COORD_ONE, 0, 0, 0, CLASS_X_AXIS);
      push_sample(0, 0, 0, 0, CLASS_X_AXIS);
      push_sample(-8192, 0, 0, 0, CLASS_X_AXIS);
      push_sample(0, 0, COORD_ONE, 4500, CLASS_TOP_RIGHT);
      push_sample(0, 0, COORD_ONE, -4500, CLASS_TOP_LEFT);
      push_sample(0, 0, COORD_ONE, 4500, CLASS_BOTTOM_LEFT);
      push_sample(0, 0, COORD_ONE, -4500, CLASS_BOTTOM_RIGHT);
      push_sample(0, 0, 8191, ANGLE_FULL, CLASS_TOP_RIGHT);
      push_sample(0, 0, 2048, -ANGLE_FULL, CLASS_TOP_LEFT);
      push_sample(0, 0, 2048, 16383, CLASS_BOTTOM_LEFT);
      push_sample(0, 0, 2048, -16384, CLASS_BOTTOM_RIGHT);
      push_sample(0, 0, 0, 0, CLASS_TOP_RIGHT);
      push_sample(0, 0, 1, 1, CLASS_TOP_LEFT);
      wait_idle();

      run_phase(DUTY_FULL, 0, 0, 0, 0, 180, 1'b1);
      run_phase(16383, 16383, 1, 83, 0, 180, 1'b0);
      run_phase(3000, 7000, 0, 0, 83, 180, 1'b0);
      run_phase(0, 0, 1, 6, 6, 180, 1'b0);
      run_phase($urandom_range(16383), $urandom_range(DUTY_FULL), $urandom_range(1),
                0, 0, 180, 1'b0);
      run_phase(DUTY_FULL, DUTY_FULL, 1, 6, 6, 180, 1'b0);

      if (mismatch_count == 0) begin
         $display("tb_joystick_differential_drive_mixer passed");
      end else begin
         $display("tb_joystick_differential_drive_mixer failed");
      end
      $finish;
   end

endmodule
